/* design/mtep_pkg.sv */
package mtep_pkg;

   // Byte role codes shown on the result channel
   localparam logic [2:0] ROLE_DELTA   = 3'd0;
   localparam logic [2:0] ROLE_STATUS  = 3'd1;
   localparam logic [2:0] ROLE_CHAN    = 3'd2;
   localparam logic [2:0] ROLE_MTYPE   = 3'd3;
   localparam logic [2:0] ROLE_LENGTH  = 3'd4;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd5;

   // Status codes and status nibbles with their own event layout
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [3:0] NIB_PROG     = 4'hC;
   localparam logic [3:0] NIB_CHPRESS  = 4'hD;
   localparam logic [3:0] NIB_SYSTEM   = 4'hF;

   // Variable-length quantity limits
   localparam int unsigned QTY_BITS   = 28;
   localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;
   localparam logic [2:0] QCNT_SAT      = 3'd7;

   // Width of the packed result channel payload
   localparam int unsigned RSP_DATA_BITS = 56;

   // One input transaction
   typedef struct packed {
      logic       track_start;
      logic [7:0] stream_byte;
   } in_item_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  event_status;
      logic [7:0]  meta_kind;
      logic [31:0] event_time;
      logic        used_running;
      logic        event_last;
      logic        empty_event_before;
      logic        vlq_too_long;
   } rsp_item_type;

endpackage

/* design/mtep_in_reg.sv */
module mtep_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mtep_pkg::in_item_type req_item,
   input  logic                 take,       // held item moves on this cycle
   output logic                 item_valid,
   output mtep_pkg::in_item_type item
);

   logic                  valid_ff;
   mtep_pkg::in_item_type item_ff;

   // Room when empty or when the held item leaves this cycle
   assign req_tready = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

endmodule

/* design/mtep_parser.sv */
module mtep_parser #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,   // item is parsed and its result loaded
   input  mtep_pkg::in_item_type item,
   output mtep_pkg::rsp_item_type result
);

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_DATA,
      PH_MTYPE,
      PH_MLEN,
      PH_PAYLOAD,
      PH_XLEN
   } phase_type;

   localparam int unsigned QB = mtep_pkg::QTY_BITS;

   phase_type              phase_ff, phase_in, phase_mid;
   logic [7:0]             running_ff, running_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [QB-1:0]          qacc_ff, qacc_in;
   logic [2:0]             qcnt_ff, qcnt_in;
   logic [QB-1:0]          remain_ff, remain_in, remain_mid;
   logic [7:0]             status_ff, status_in;
   logic [7:0]             meta_ff, meta_in;
   logic                   used_ff, used_in;

   logic [7:0]             b;
   logic [QB-1:0]          vlq_acc;
   logic [2:0]             vlq_cnt;
   logic                   vlq_long;
   logic                   vlq_done;
   logic                   open_req;
   logic                   consumed;
   logic [7:0]             open_st;
   logic [QB-1:0]          rem_dec;
   logic [2:0]             role;
   logic                   last;
   logic                   empty;
   logic                   too_long;
   logic [63:0]            time_wide;

   assign b = item.stream_byte;

   // Quantity reader: next accumulator and byte count
   always_comb begin
      vlq_acc  = {qacc_ff[QB-8:0], b[6:0]};
      vlq_cnt  = (qcnt_ff < mtep_pkg::QCNT_SAT) ? qcnt_ff + 3'd1 : qcnt_ff;
      vlq_long = vlq_cnt > mtep_pkg::VLQ_MAX_BYTES;
      vlq_done = !b[7];
   end

   // Status handling, then per-phase byte handling
   always_comb begin
      running_in = running_ff;
      time_in    = time_ff;
      qacc_in    = qacc_ff;
      qcnt_in    = qcnt_ff;
      status_in  = status_ff;
      meta_in    = meta_ff;
      used_in    = used_ff;
      phase_mid  = phase_ff;
      remain_mid = remain_ff;
      open_req   = 1'b0;
      open_st    = '0;
      consumed   = 1'b0;
      role       = mtep_pkg::ROLE_DELTA;
      last       = 1'b0;
      empty      = 1'b0;
      too_long   = 1'b0;
      rem_dec    = '0;

      if (item.track_start) begin
         time_in    = '0;
         running_in = '0;
      end

      // Status expected: explicit, running, or none in force
      if (phase_ff == PH_STATUS) begin
         if (b[7]) begin
            used_in  = 1'b0;
            meta_in  = '0;
            open_req = 1'b1;
            open_st  = b;
            role     = mtep_pkg::ROLE_STATUS;
            consumed = 1'b1;
         end else if (!running_in[7]) begin
            status_in = '0;
            empty     = 1'b1;
            phase_mid = PH_DELTA;
         end else begin
            used_in  = 1'b1;
            meta_in  = '0;
            open_req = 1'b1;
            open_st  = running_in;
         end
      end

      // Open the event: layout follows the status
      if (open_req) begin
         status_in = open_st;
         if (open_st == mtep_pkg::STATUS_META) begin
            phase_mid = PH_MTYPE;
         end else begin
            running_in = open_st;
            case (open_st[7:4])
               mtep_pkg::NIB_PROG, mtep_pkg::NIB_CHPRESS: begin
                  remain_mid = QB'(1);
                  phase_mid  = PH_DATA;
               end
               mtep_pkg::NIB_SYSTEM: begin
                  phase_mid = PH_XLEN;
               end
               default: begin
                  remain_mid = QB'(2);
                  phase_mid  = PH_DATA;
               end
            endcase
         end
      end

      phase_in  = phase_mid;
      remain_in = remain_mid;

      if (!consumed) begin
         unique case (phase_mid)
            PH_DATA, PH_PAYLOAD: begin
               role = (phase_mid == PH_DATA) ? mtep_pkg::ROLE_CHAN : mtep_pkg::ROLE_PAYLOAD;
               rem_dec   = remain_mid - QB'(remain_mid != '0);
               remain_in = rem_dec;
               if (rem_dec == '0) begin
                  last     = 1'b1;
                  phase_in = PH_DELTA;
               end
            end
            PH_MTYPE: begin
               role     = mtep_pkg::ROLE_MTYPE;
               meta_in  = b;
               phase_in = PH_MLEN;
            end
            PH_MLEN, PH_XLEN: begin
               role     = mtep_pkg::ROLE_LENGTH;
               too_long = vlq_long;
               if (vlq_done) begin
                  qacc_in   = '0;
                  qcnt_in   = '0;
                  remain_in = vlq_acc;
                  if (vlq_acc == '0) begin
                     last     = 1'b1;
                     phase_in = PH_DELTA;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  qacc_in = vlq_acc;
                  qcnt_in = vlq_cnt;
               end
            end
            default: begin
               // Delta time byte
               role      = mtep_pkg::ROLE_DELTA;
               phase_in  = PH_DELTA;
               status_in = '0;
               meta_in   = '0;
               used_in   = 1'b0;
               too_long  = vlq_long;
               if (vlq_done) begin
                  qacc_in  = '0;
                  qcnt_in  = '0;
                  time_in  = time_in + TIME_BITS'(vlq_acc);
                  phase_in = PH_STATUS;
               end else begin
                  qacc_in = vlq_acc;
                  qcnt_in = vlq_cnt;
               end
            end
         endcase
      end
   end

   // Result of the byte now at the input register
   always_comb begin
      time_wide                 = 64'(time_in);
      result.byte_role          = role;
      result.event_status       = status_in;
      result.meta_kind          = meta_in;
      result.event_time         = time_wide[31:0];
      result.used_running       = used_in;
      result.event_last         = last;
      result.empty_event_before = empty;
      result.vlq_too_long       = too_long;
   end

   // Parse state, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DELTA;
         running_ff <= '0;
         time_ff    <= '0;
         qacc_ff    <= '0;
         qcnt_ff    <= '0;
         remain_ff  <= '0;
         status_ff  <= '0;
         meta_ff    <= '0;
         used_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         running_ff <= running_in;
         time_ff    <= time_in;
         qacc_ff    <= qacc_in;
         qcnt_ff    <= qcnt_in;
         remain_ff  <= remain_in;
         status_ff  <= status_in;
         meta_ff    <= meta_in;
         used_ff    <= used_in;
      end
   end

endmodule

/* design/mtep_out_reg.sv */
module mtep_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,      // new result this cycle
   input  mtep_pkg::rsp_item_type result,
   output logic                   room,      // register free or being emptied
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output mtep_pkg::rsp_item_type rsp_item
);

   logic                   valid_ff;
   mtep_pkg::rsp_item_type item_ff;

   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room) begin
         valid_ff <= load;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

endmodule

/* design/midi_track_event_parser_top.sv */
// Channel  Ports             Direction  Contents
// req      req_t*            in         one track byte and its track start flag
// rsp      rsp_t*            out        the byte's role, event status, meta type, time, flags
//
// One byte per cycle sustained while results are taken. A byte is held in the input
// register; its parse is one pass of logic into the result register, including the
// delta add into the tick time, and the result is offered from that register.
// Synchronous active-high reset empties both registers and returns the parser
// to expecting a delta time, with time and running status at zero.
// A stalled result holds in the result register; the input register then takes at
// most one byte, and the input channel stalls until the result is taken.
module midi_track_event_parser_top #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tuser,   // [0] track_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] event_status, [15:8] meta_kind,
                                    // [47:16] event_time, [48] used_running,
                                    // [49] empty_event_before, [50] vlq_too_long
   output logic [2:0]  rsp_tuser,   // [2:0] byte_role
   output logic        rsp_tlast    // event_last
);

   mtep_pkg::in_item_type  req_item;
   mtep_pkg::in_item_type  item;
   mtep_pkg::rsp_item_type result;
   mtep_pkg::rsp_item_type rsp_item;
   logic                   item_valid;
   logic                   room;
   logic                   advance;

   assign req_item.stream_byte = req_tdata;
   assign req_item.track_start = req_tuser;

   // A byte is parsed when it is held and the result register has room
   assign advance = item_valid && room;

   mtep_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mtep_parser #(
      .TIME_BITS (TIME_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   mtep_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result transaction
   assign rsp_tdata = {
      5'b0,
      rsp_item.vlq_too_long,
      rsp_item.empty_event_before,
      rsp_item.used_running,
      rsp_item.event_time,
      rsp_item.meta_kind,
      rsp_item.event_status
   };
   assign rsp_tuser = rsp_item.byte_role;
   assign rsp_tlast = rsp_item.event_last;

endmodule

/* design/mtep_checker.sv */
module mtep_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Nothing is offered right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

   // Delta bytes carry no event status, meta type or running flag and close nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mtep_pkg::ROLE_DELTA |->
         rsp_tdata[15:0] == 16'd0 && !rsp_tdata[48] && !rsp_tlast)
      else $error("delta byte with event fields set");

   // A status byte has bit 7 set, no running status and no overlong flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mtep_pkg::ROLE_STATUS |->
         rsp_tdata[7] && !rsp_tdata[48] && !rsp_tdata[50])
      else $error("status byte fields inconsistent");

   // An empty event is reported only on a byte that begins the next delta
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49] |-> rsp_tuser == mtep_pkg::ROLE_DELTA)
      else $error("empty event flagged on a non-delta byte");

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* verif/testbench.sv */
module testbench;

   // Parse phases of the byte-tagging predictor
   typedef enum logic [2:0] {
      PH_DELTA, PH_STATUS, PH_DATA, PH_MTYPE, PH_MLEN, PH_PAYLOAD, PH_XLEN
   } parse_phase_type;

   // One pending track byte with its sender pacing
   typedef struct {
      logic [7:0]  b;
      logic        start;
      int unsigned gap;
      bit          drain;
   } track_byte_type;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned TRACK_ITEMS = 1350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Bytes still to send and byte tags still to arrive
   track_byte_type         track_bytes[$];
   mtep_pkg::rsp_item_type expected_tags[$];

   // Predictor state
   parse_phase_type phase        = PH_DELTA;
   logic [7:0]      run_status   = '0;
   logic [31:0]     tick_time    = '0;
   logic [27:0]     qty_val      = '0;
   logic [2:0]      qty_cnt      = '0;
   logic [27:0]     remain       = '0;
   logic [7:0]      cur_status   = '0;
   logic [7:0]      cur_meta     = '0;
   logic            from_running = 1'b0;

   // Driver, monitor and stimulus bookkeeping
   track_byte_type         slot;
   mtep_pkg::rsp_item_type sent_tag;
   mtep_pkg::rsp_item_type want;
   mtep_pkg::rsp_item_type got;
   int unsigned  gap_left     = 0;
   bit           gap_armed    = 1'b0;
   int unsigned  stall_left   = 0;
   int unsigned  stall_mode   = 1;
   int unsigned  results_seen = 0;
   int unsigned  idle_cycles  = 0;
   int unsigned  errors       = 0;
   int unsigned  gap_mode     = 0;
   bit           drain_next   = 1'b0;
   logic [7:0]   gen_running  = '0;

   midi_track_event_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Wait drawn per transaction: none, uniform 0..11, or mostly none
   function automatic int unsigned draw_wait(input int unsigned mode);
      if (mode == 0) return 0;
      if (mode == 1) return $urandom_range(0, 11);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
   endfunction

   // Variable-length quantity reader, 28-bit value, count saturates
   function automatic void take_qty(input logic [7:0] b, output logic done,
                                    output logic [27:0] v, output logic too_long);
      qty_val = {qty_val[20:0], b[6:0]};
      if (qty_cnt < mtep_pkg::QCNT_SAT) qty_cnt = qty_cnt + 3'd1;
      too_long = (qty_cnt > mtep_pkg::VLQ_MAX_BYTES);
      done = ~b[7];
      v = qty_val;
      if (done) begin
         qty_val = '0;
         qty_cnt = '0;
      end
   endfunction

   // Start an event with a status that has bit 7 set
   function automatic void open_event(input logic [7:0] st);
      cur_status = st;
      if (st == mtep_pkg::STATUS_META) begin
         phase = PH_MTYPE;
         return;
      end
      run_status = st;
      case (st[7:4])
         mtep_pkg::NIB_PROG, mtep_pkg::NIB_CHPRESS: begin
            remain = 28'd1;
            phase  = PH_DATA;
         end
         mtep_pkg::NIB_SYSTEM: phase = PH_XLEN;
         default: begin
            remain = 28'd2;
            phase  = PH_DATA;
         end
      endcase
   endfunction

   // Predict the tag of one track byte
   function automatic void tag_byte(input logic [7:0] b, input logic start,
                                    output mtep_pkg::rsp_item_type r);
      logic [2:0]  role;
      logic        last;
      logic        empty;
      logic        too_long;
      logic        taken;
      logic        done;
      logic [27:0] v;
      role = mtep_pkg::ROLE_DELTA;
      last = 1'b0;
      empty = 1'b0;
      too_long = 1'b0;
      taken = 1'b0;
      done = 1'b0;
      v = '0;
      if (start) begin
         tick_time  = '0;
         run_status = '0;
      end
      if (phase == PH_STATUS) begin
         if (b[7]) begin
            from_running = 1'b0;
            cur_meta = '0;
            open_event(b);
            role = mtep_pkg::ROLE_STATUS;
            taken = 1'b1;
         end else if (run_status < 8'h80) begin
            // no running status: empty event, byte starts the next delta
            cur_status = '0;
            empty = 1'b1;
            phase = PH_DELTA;
         end else begin
            from_running = 1'b1;
            cur_meta = '0;
            open_event(run_status);
         end
      end
      if (!taken) begin
         case (phase)
            PH_DATA, PH_PAYLOAD: begin
               role = (phase == PH_DATA) ? mtep_pkg::ROLE_CHAN : mtep_pkg::ROLE_PAYLOAD;
               if (remain != 0) remain = remain - 28'd1;
               if (remain == 0) begin
                  last = 1'b1;
                  phase = PH_DELTA;
               end
            end
            PH_MTYPE: begin
               role = mtep_pkg::ROLE_MTYPE;
               cur_meta = b;
               phase = PH_MLEN;
            end
            PH_MLEN, PH_XLEN: begin
               role = mtep_pkg::ROLE_LENGTH;
               take_qty(b, done, v, too_long);
               if (done) begin
                  remain = v;
                  if (v == 0) begin
                     last = 1'b1;
                     phase = PH_DELTA;
                  end else begin
                     phase = PH_PAYLOAD;
                  end
               end
            end
            default: begin
               role = mtep_pkg::ROLE_DELTA;
               phase = PH_DELTA;
               cur_status = '0;
               cur_meta = '0;
               from_running = 1'b0;
               take_qty(b, done, v, too_long);
               if (done) begin
                  tick_time = tick_time + {4'd0, v};
                  phase = PH_STATUS;
               end
            end
         endcase
      end
      r.byte_role          = role;
      r.event_status       = cur_status;
      r.meta_kind          = cur_meta;
      r.event_time         = tick_time;
      r.used_running       = from_running;
      r.event_last         = last;
      r.empty_event_before = empty;
      r.vlq_too_long       = too_long;
   endfunction

   function automatic logic mid_start();
      return ($urandom_range(0, 599) == 0);
   endfunction

   // Queue one byte; sender pacing changes in segments
   function automatic void push_byte(input logic [7:0] b, input logic start);
      track_byte_type s;
      if (track_bytes.size() % 97 == 0) gap_mode = $urandom_range(0, 2);
      if (start) gen_running = '0;
      s.b     = b;
      s.start = start;
      s.gap   = draw_wait(gap_mode);
      s.drain = drain_next || ($urandom_range(0, 299) == 0);
      drain_next = 1'b0;
      track_bytes.insert(track_bytes.size(), s);
   endfunction

   // Queue a quantity, optionally padded with leading continuation bytes
   function automatic void push_qty(input logic [27:0] v, input int unsigned pad,
                                    input logic rnd_pad, input logic start);
      int unsigned n;
      logic [7:0]  b;
      logic        first;
      n = 1;
      first = start;
      while (n < 4 && (v >> (7 * n)) != 0) n++;
      repeat (pad) begin
         b = rnd_pad ? (8'h80 | 8'($urandom_range(0, 127))) : 8'h80;
         push_byte(b, first);
         first = mid_start();
      end
      for (int i = n - 1; i >= 0; i--) begin
         b = {(i != 0), 7'(v >> (7 * i))};
         push_byte(b, first);
         first = mid_start();
      end
   endfunction

   // Queue one event with random content, mostly well formed
   function automatic void push_event();
      int unsigned  r;
      int unsigned  len;
      int unsigned  pad;
      int unsigned  n;
      logic [27:0]  dv;
      logic [7:0]   st;
      bit           omit;
      // stray byte now and then
      if ($urandom_range(0, 24) == 0) push_byte(8'($urandom_range(0, 255)), mid_start());
      // delta time
      r = $urandom_range(0, 19);
      pad = 0;
      if (r < 9) dv = 28'($urandom_range(0, 127));
      else if (r < 13) dv = 28'($urandom_range(128, 16383));
      else if (r < 14) dv = 28'($urandom_range(16384, 2097151));
      else if (r < 18) dv = {7'($urandom_range(64, 127)), 21'($urandom_range(0, 2097151))};
      else begin
         dv = 28'($urandom_range(0, 4000));
         pad = $urandom_range(1, 6);
      end
      push_qty(dv, pad, 1'b1, $urandom_range(0, 299) == 0);
      // status, or running status
      r = $urandom_range(0, 15);
      omit = (r < 4);
      if (omit && !gen_running[7]) begin
         push_byte(8'($urandom_range(0, 127)), mid_start());
         r = $urandom_range(4, 15);
         omit = 1'b0;
      end
      if (omit) st = gen_running;
      else if (r < 11) st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
      else if (r < 14) st = mtep_pkg::STATUS_META;
      else st = 8'($urandom_range(8'hF0, 8'hFE));
      if (!omit) push_byte(st, mid_start());
      if (st != mtep_pkg::STATUS_META) gen_running = st;
      if (st == mtep_pkg::STATUS_META) push_byte(8'($urandom_range(0, 255)), mid_start());
      if (st == mtep_pkg::STATUS_META || st[7:4] == mtep_pkg::NIB_SYSTEM) begin
         r = $urandom_range(0, 39);
         pad = 0;
         if (r < 4) len = 0;
         else if (r < 37) len = $urandom_range(1, 6);
         else if (r < 38) len = $urandom_range(128, 140);
         else begin
            len = $urandom_range(0, 3);
            pad = $urandom_range(1, 4);
         end
         push_qty(28'(len), pad, 1'b0, mid_start());
         repeat (len) push_byte(8'($urandom_range(0, 255)), mid_start());
      end else begin
         n = (st[7:4] == mtep_pkg::NIB_PROG || st[7:4] == mtep_pkg::NIB_CHPRESS) ? 1 : 2;
         for (int i = 0; i < n; i++) begin
            if ((omit && i == 0) || $urandom_range(0, 9) != 0)
               push_byte(8'($urandom_range(0, 127)), mid_start());
            else
               push_byte(8'($urandom_range(128, 255)), mid_start());
         end
      end
   endfunction

   // Driver: predicts each accepted byte, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tag_byte(req_tdata, req_tuser, sent_tag);
            expected_tags.insert(expected_tags.size(), sent_tag);
         end
         if (!req_tvalid || req_tready) begin
            if (track_bytes.size() != 0 && !gap_armed) begin
               gap_left = track_bytes[0].gap;
               gap_armed = 1'b1;
            end
            if (track_bytes.size() == 0 || gap_left != 0 ||
                (track_bytes[0].drain && expected_tags.size() != 0)) begin
               if (gap_left != 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               slot = track_bytes.pop_front();
               gap_armed = 1'b0;
               req_tdata  <= slot.b;
               req_tuser  <= slot.start;
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   task automatic check_field(input string what, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
      end
   endtask

   // Monitor: checks each result transaction, stalls in segments
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.byte_role          = rsp_tuser;
            got.event_status       = rsp_tdata[7:0];
            got.meta_kind          = rsp_tdata[15:8];
            got.event_time         = rsp_tdata[47:16];
            got.used_running       = rsp_tdata[48];
            got.empty_event_before = rsp_tdata[49];
            got.vlq_too_long       = rsp_tdata[50];
            got.event_last         = rsp_tlast;
            if (expected_tags.size() == 0) begin
               errors++;
               $display("%0t unexpected result: expected none, actual %h", $time, got);
            end else begin
               want = expected_tags.pop_front();
               check_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
               check_field("event_status", 32'(want.event_status),
                           32'(got.event_status));
               check_field("meta_kind", 32'(want.meta_kind), 32'(got.meta_kind));
               check_field("event_time", want.event_time, got.event_time);
               check_field("used_running", 32'(want.used_running),
                           32'(got.used_running));
               check_field("event_last", 32'(want.event_last), 32'(got.event_last));
               check_field("empty_event_before", 32'(want.empty_event_before),
                           32'(got.empty_event_before));
               check_field("vlq_too_long", 32'(want.vlq_too_long),
                           32'(got.vlq_too_long));
            end
            results_seen++;
            if (results_seen % 64 == 0) stall_mode = $urandom_range(0, 2);
            stall_left = draw_wait(stall_mode);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin : stim
      logic [8:0] opening [0:29];
      // note on with a data byte carrying bit 7; two-byte delta then running
      // status; program change; zero-length meta; overlong delta; running
      // status again; track start on a data byte, no running status; pitch bend
      opening = '{9'h100, 9'h090, 9'h07F, 9'h080,
                  9'h081, 9'h000, 9'h040, 9'h07F,
                  9'h000, 9'h0C5, 9'h0FF,
                  9'h000, 9'h0FF, 9'h02F, 9'h000,
                  9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
                  9'h000, 9'h0F0, 9'h001, 9'h055,
                  9'h000, 9'h112, 9'h0E3, 9'h000, 9'h07F};
      foreach (opening[i]) push_byte(opening[i][7:0], opening[i][8]);
      gen_running = 8'hE3;
      // hold the sender until the directed part has fully drained
      drain_next = 1'b1;
      while (track_bytes.size() < TRACK_ITEMS) push_event();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (track_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* midi_track_event_parser_top.f */
design/mtep_pkg.sv
design/mtep_in_reg.sv
design/mtep_parser.sv
design/mtep_out_reg.sv
design/midi_track_event_parser_top.sv
design/mtep_checker.sv
verif/testbench.sv
